/* rtl/core/vdol_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdol_pkg: shared types and constants for the voxel DAG occupancy lookup
// Memory geometry, level limits, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package vdol_pkg;

    localparam int MEM_WORDS  = 4096;
    localparam int MAX_LEVELS = 10;
    localparam int WORD_W     = 64;
    localparam int ADDR_W     = $clog2(MEM_WORDS);
    localparam int COORD_W    = 10;
    localparam int LEVEL_W    = 4;                    // level_count register
    localparam int LVL_IDX_W  = $clog2(MAX_LEVELS);   // Morton digit index
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 12;
    localparam int MIN_LEVELS = 3;
    localparam int CHILD_BITS = 8;
    localparam int LEAF_IDX_W = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROOT_ADDRESS = 4'd0,
        CFG_LEVEL_COUNT  = 4'd1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROOT,
        S_MASK,
        S_PTR,
        S_LEAF,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        RD_NODE,    // mask word of current node
        RD_SLOT,    // child pointer slot behind the mask
        RD_PTR      // word just read is the next node address
    } rd_sel_t;

    typedef struct packed {
        logic    wr_en;
        logic    load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    descend;
        logic    res_miss;
        logic    res_leaf;
        logic    out_load;
    } vdol_cmd_t;

    typedef struct packed {
        logic child_present;
        logic last_inner;
        logic out_free;
    } vdol_status_t;

    // count of set child bits below the selected octant
    function automatic logic [3:0] count_below(input logic [CHILD_BITS-1:0] mask,
                                               input logic [2:0] digit);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < CHILD_BITS; i++) begin
            if ((i < int'(digit)) && mask[i]) begin
                n = n + 4'd1;
            end
        end
        return n;
    endfunction

endpackage

/* rtl/core/vdol_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdol_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module vdol_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/vdol_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdol_ctrl: walk sequencer
// Accepts requests and steps the datapath through root, mask, pointer, leaf.
// ----------------------------------------------------------------------------
module vdol_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_func,
    input  vdol_pkg::vdol_status_t status,
    output vdol_pkg::vdol_cmd_t    cmd
);
    import vdol_pkg::*;

    state_t state_reg, state_next;
    logic   accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && s_func) state_next = S_ROOT;
            end
            S_ROOT: state_next = S_MASK;
            S_MASK: begin
                state_next = status.child_present ? S_PTR : S_OUT;
            end
            S_PTR: begin
                state_next = status.last_inner ? S_LEAF : S_MASK;
            end
            S_LEAF: state_next = S_OUT;
            S_OUT: begin
                if (status.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.rd_sel   = RD_NODE;
        cmd.wr_en    = accept && !s_func;
        cmd.load     = accept && s_func;
        unique case (state_reg)
            S_IDLE: ;
            S_ROOT: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_NODE;
            end
            S_MASK: begin
                if (status.child_present) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_SLOT;
                end else begin
                    cmd.res_miss = 1'b1;
                end
            end
            S_PTR: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RD_PTR;
                cmd.descend = 1'b1;
            end
            S_LEAF: cmd.res_leaf = 1'b1;
            S_OUT:  cmd.out_load = status.out_free;
            default: ;
        endcase
    end

endmodule

/* rtl/core/vdol_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdol_dp: lookup datapath
// Config registers, node memory, walk registers and the result register.
// ----------------------------------------------------------------------------
module vdol_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  vdol_pkg::vdol_cmd_t                cmd,
    output vdol_pkg::vdol_status_t             status,
    input  logic                               cfg_valid,
    input  logic [vdol_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vdol_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [vdol_pkg::ADDR_W-1:0]        s_word_address,
    input  logic [vdol_pkg::WORD_W-1:0]        s_word_data,
    input  logic [vdol_pkg::COORD_W-1:0]       s_coord_x,
    input  logic [vdol_pkg::COORD_W-1:0]       s_coord_y,
    input  logic [vdol_pkg::COORD_W-1:0]       s_coord_z,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_occupied
);
    import vdol_pkg::*;

    logic [ADDR_W-1:0]    root_reg;
    logic [LEVEL_W-1:0]   levels_reg;
    logic [COORD_W-1:0]   x_reg, y_reg, z_reg;
    logic [ADDR_W-1:0]    node_reg, node_next;
    logic [LVL_IDX_W-1:0] lvl_reg, lvl_next;
    logic                 res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 occ_reg, occ_next;

    logic [LEVEL_W:0]     lv_ext;
    logic [LEVEL_W:0]     lv_eff;
    logic [2:0]           digit;
    logic [LEAF_IDX_W-1:0] leaf_idx;
    logic [WORD_W-1:0]    rd_data;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    slot_addr;

    // config writes; unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg   <= '0;
            levels_reg <= LEVEL_W'(MIN_LEVELS);
        end else if (cfg_valid) begin
            if (cfg_index == CFG_ROOT_ADDRESS) root_reg <= cfg_data[ADDR_W-1:0];
            if (cfg_index == CFG_LEVEL_COUNT)  levels_reg <= cfg_data[LEVEL_W-1:0];
        end
    end

    // clamp level count, start index = levels - 1
    always_comb begin
        lv_ext = {1'b0, levels_reg};
        priority if (lv_ext < (LEVEL_W+1)'(MIN_LEVELS)) lv_eff = (LEVEL_W+1)'(MIN_LEVELS);
        else if (lv_ext > (LEVEL_W+1)'(MAX_LEVELS))     lv_eff = (LEVEL_W+1)'(MAX_LEVELS);
        else                                            lv_eff = lv_ext;
    end

    assign digit     = {z_reg[lvl_reg], y_reg[lvl_reg], x_reg[lvl_reg]};
    assign leaf_idx  = {z_reg[1], y_reg[1], x_reg[1], z_reg[0], y_reg[0], x_reg[0]};
    assign slot_addr = node_reg + ADDR_W'(1)
                     + ADDR_W'(count_below(rd_data[CHILD_BITS-1:0], digit));

    always_comb begin
        unique case (cmd.rd_sel)
            RD_NODE: rd_addr = node_reg;
            RD_SLOT: rd_addr = slot_addr;
            RD_PTR:  rd_addr = rd_data[ADDR_W-1:0];
            default: rd_addr = node_reg;
        endcase
    end

    vdol_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_WORDS)
    ) u_mem (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (s_word_address),
        .wdata (s_word_data),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb begin
        node_next = node_reg;
        lvl_next  = lvl_reg;
        if (cmd.load) begin
            node_next = root_reg;
            lvl_next  = LVL_IDX_W'(lv_eff - (LEVEL_W+1)'(1));
        end else if (cmd.descend) begin
            node_next = rd_data[ADDR_W-1:0];
            lvl_next  = lvl_reg - LVL_IDX_W'(1);
        end
    end

    always_comb begin
        res_next = res_reg;
        if (cmd.res_miss) res_next = 1'b0;
        if (cmd.res_leaf) res_next = rd_data[leaf_idx];
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        occ_next     = occ_reg;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            occ_next     = res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg <= s_coord_x;
            y_reg <= s_coord_y;
            z_reg <= s_coord_z;
        end
        node_reg <= node_next;
        lvl_reg  <= lvl_next;
        res_reg  <= res_next;
        occ_reg  <= occ_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign status.child_present = rd_data[digit];
    assign status.last_inner    = (lvl_reg == LVL_IDX_W'(2));
    assign status.out_free      = !m_valid_reg || m_ready;

    assign m_valid    = m_valid_reg;
    assign m_occupied = occ_reg;

endmodule

/* rtl/core/voxel_dag_occupancy_lookup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_dag_occupancy_lookup: occupancy query over a compacted voxel DAG
// Holds a 4096 x 64-bit node memory loaded by write requests and answers
// lookup requests with one occupied bit each.
// ----------------------------------------------------------------------------
// Usage: load a complete DAG through write requests (func = 0, word_address,
// word_data), then set root_address (index 0) and level_count (index 1,
// clamped to 3..10) on the cfg port while idle. A lookup request (func = 1)
// walks level_count-2 inner nodes from the root, using one Morton digit
// {z,y,x} per level: mask word bit clear means empty, otherwise the next
// node address is read from node+1+popcount(mask bits below the digit).
// The last six Morton bits pick a bit of the 64-bit leaf word. A write
// request is written to node memory as it is accepted. A lookup raises
// m_valid once its result is loaded into the output register, sooner on
// an early miss; the load waits while that register holds a result not
// yet taken, and s_ready returns in the same cycle that m_valid rises.
// Lookup time is set by the single read port of the node memory and its
// registered read, since each mask read and pointer read depends on the
// word before it. Requests are taken one at a time; a finished result sits
// in the output register while the next request is accepted. Reading
// words that were never written gives undefined answers.
// ----------------------------------------------------------------------------
module voxel_dag_occupancy_lookup (
    input  logic                               aclk,
    input  logic                               aresetn,
    // request channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_func,
    input  logic [vdol_pkg::ADDR_W-1:0]        s_word_address,
    input  logic [vdol_pkg::WORD_W-1:0]        s_word_data,
    input  logic [vdol_pkg::COORD_W-1:0]       s_coord_x,
    input  logic [vdol_pkg::COORD_W-1:0]       s_coord_y,
    input  logic [vdol_pkg::COORD_W-1:0]       s_coord_z,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_occupied,
    // register write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [vdol_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vdol_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import vdol_pkg::*;

    vdol_cmd_t    cmd;
    vdol_status_t status;

    // registers are always writable
    assign cfg_ready = 1'b1;

    // sequencer: one request in flight, drives memory reads and walk steps
    vdol_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .status  (status),
        .cmd     (cmd)
    );

    // node memory, walk registers, config and output register
    vdol_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_word_address (s_word_address),
        .s_word_data    (s_word_data),
        .s_coord_x      (s_coord_x),
        .s_coord_y      (s_coord_y),
        .s_coord_z      (s_coord_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_occupied     (m_occupied)
    );

endmodule

/* dv/voxel_dag_occupancy_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_dag_occupancy_checker: scoreboard for the voxel DAG occupancy lookup
// Mirrors node memory writes and register writes seen on the ports, predicts
// the occupied bit of every accepted lookup request and compares in order.
// ----------------------------------------------------------------------------
package vdol_tb_pkg;

    typedef enum logic {
        FUNC_WRITE  = 1'b0,
        FUNC_LOOKUP = 1'b1
    } func_t;

endpackage

module voxel_dag_occupancy_checker
    import vdol_pkg::*;
    import vdol_tb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_func,
    input  logic [ADDR_W-1:0]     s_word_address,
    input  logic [WORD_W-1:0]     s_word_data,
    input  logic [COORD_W-1:0]    s_coord_x,
    input  logic [COORD_W-1:0]    s_coord_y,
    input  logic [COORD_W-1:0]    s_coord_z,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  m_occupied,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending,
    output int                    hits
);

    logic [WORD_W-1:0]  dag_words [MEM_WORDS];
    logic [ADDR_W-1:0]  root_reg;
    logic [LEVEL_W-1:0] depth_reg;
    bit                 expected_occupancy [$];
    int                 err_count = 0;
    int                 hit_count = 0;

    // walk the inner nodes from the root, then pick the leaf bit
    function automatic bit occupancy_at(input logic [COORD_W-1:0] x,
                                        input logic [COORD_W-1:0] y,
                                        input logic [COORD_W-1:0] z);
        int                    levels;
        logic [ADDR_W-1:0]     node;
        logic [WORD_W-1:0]     mask;
        logic [2:0]            octant;
        logic [LEAF_IDX_W-1:0] bit_sel;
        levels = int'(depth_reg);
        if (levels < MIN_LEVELS) levels = MIN_LEVELS;
        if (levels > MAX_LEVELS) levels = MAX_LEVELS;
        node = root_reg;
        for (int b = levels - 1; b >= 2; b--) begin
            octant = {z[b], y[b], x[b]};
            mask   = dag_words[node];
            if (!mask[octant]) return 1'b0;
            node = dag_words[ADDR_W'(node + 1 + $countones(mask[CHILD_BITS-1:0] &
                                     ((8'd1 << octant) - 8'd1)))][ADDR_W-1:0];
        end
        bit_sel = {z[1], y[1], x[1], z[0], y[0], x[0]};
        return dag_words[node][bit_sel];
    endfunction

    always @(posedge aclk) begin
        bit want;
        if (!aresetn) begin
            root_reg  = '0;
            depth_reg = LEVEL_W'(MIN_LEVELS);
            expected_occupancy.delete();
        end else begin
            // results first: a result never belongs to a request taken at the same edge
            if (m_valid && m_ready) begin
                if (expected_occupancy.size() == 0) begin
                    err_count++;
                    $display("%0t: result with no lookup outstanding, expected none, got %0d",
                             $time, m_occupied);
                end else begin
                    want = expected_occupancy.pop_front();
                    if (m_occupied !== want) begin
                        err_count++;
                        $display("%0t: occupied mismatch, expected %0d, got %0d",
                                 $time, want, m_occupied);
                    end else if (want) begin
                        hit_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ROOT_ADDRESS: root_reg  = cfg_data[ADDR_W-1:0];
                    CFG_LEVEL_COUNT:  depth_reg = cfg_data[LEVEL_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_func == FUNC_LOOKUP) begin
                    expected_occupancy.push_back(occupancy_at(s_coord_x, s_coord_y, s_coord_z));
                end else begin
                    dag_words[s_word_address] = s_word_data;
                end
            end
        end
        errors  <= err_count;
        pending <= expected_occupancy.size();
        hits    <= hit_count;
    end

endmodule

/* dv/voxel_dag_occupancy_lookup_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_dag_occupancy_lookup_test: top of the occupancy lookup testbench
// Loads random compacted voxel DAGs into node memory, sets root and depth,
// and fires lookup requests that mostly follow existing paths. A checker
// beside the block predicts every occupied bit; this module only drives
// requests, throttles the result side and reports the verdict.
// ----------------------------------------------------------------------------
module voxel_dag_occupancy_lookup_test;
    import vdol_pkg::*;
    import vdol_tb_pkg::*;

    localparam int IDLE_PERCENT      = 11;
    localparam int ITEM_TARGET       = 1550;
    localparam int LOOKUPS_PER_PHASE = 100;
    localparam int NOISE_PERCENT     = 8;     // rewrites mixed into a lookup stream
    localparam int FOLLOW_PERCENT    = 75;    // lookups that trace a real path
    localparam int SETTLE_CYCLES     = 24;    // wait after the last result is due
    localparam int LIMIT_CYCLES      = 400000;
    localparam int FIRST_SPARE_INDEX = int'(CFG_LEVEL_COUNT) + 1;
    localparam int LAST_INDEX        = 2**CFG_IDX_W - 1;
    localparam int LEVEL_CODE_MAX    = 2**LEVEL_W - 1;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_func;
    logic [ADDR_W-1:0]     s_word_address;
    logic [WORD_W-1:0]     s_word_data;
    logic [COORD_W-1:0]    s_coord_x;
    logic [COORD_W-1:0]    s_coord_y;
    logic [COORD_W-1:0]    s_coord_z;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_occupied;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    hits;

    // Stimulus-side copy of what was written, used only to steer lookups
    // down paths that exist and to keep every walk inside written words.
    logic [WORD_W-1:0] dag_image [MEM_WORDS];
    logic [ADDR_W-1:0] leaf_words [$];
    logic [ADDR_W-1:0] inner_words [$];
    logic [ADDR_W-1:0] lower_level [$];
    logic [ADDR_W-1:0] upper_level [$];
    logic [ADDR_W-1:0] alloc_at;
    logic [ADDR_W-1:0] dag_root;

    bit no_gaps = 1'b0;
    int item_count   = 0;
    int write_count  = 0;
    int lookup_count = 0;
    int noise_count  = 0;
    int phase_count  = 0;
    int cycle_count  = 0;
    int setting_lo   = LEVEL_CODE_MAX;
    int setting_hi   = 0;

    // level_count values for the first phases: deepest, clamped high,
    // clamped low, shallowest, clamped again, mid-range; later ones random
    int level_plan [7] = '{10, 15, 0, 3, 2, 11, 6};

    voxel_dag_occupancy_lookup dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_word_address (s_word_address),
        .s_word_data    (s_word_data),
        .s_coord_x      (s_coord_x),
        .s_coord_y      (s_coord_y),
        .s_coord_z      (s_coord_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_occupied     (m_occupied),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    voxel_dag_occupancy_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Result side: stalls at random, except during the no-gap phase.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            m_ready <= no_gaps || ($urandom_range(99, 0) >= IDLE_PERCENT);
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("%0t: cycle limit reached, %0d lookups still due", $time, pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // One request on the s_ channel. Valid is only lowered in an idle gap,
    // so back-to-back requests keep it high with a single assignment per edge.
    task automatic send_request(input func_t op, input logic [ADDR_W-1:0] addr,
                                input logic [WORD_W-1:0] data,
                                input logic [COORD_W-1:0] x,
                                input logic [COORD_W-1:0] y,
                                input logic [COORD_W-1:0] z);
        while (!no_gaps && $urandom_range(99, 0) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_func         <= op;
        s_word_address <= addr;
        s_word_data    <= data;
        s_coord_x      <= x;
        s_coord_y      <= y;
        s_coord_z      <= z;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        item_count++;
    endtask

    // Memory write; the coordinate fields are don't-care and get noise.
    task automatic write_word(input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] data);
        send_request(FUNC_WRITE, addr, data, COORD_W'($urandom), COORD_W'($urandom),
                     COORD_W'($urandom));
        dag_image[addr] = data;
        write_count++;
    endtask

    // Lookup; the address and data fields are don't-care and get noise.
    task automatic query(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                         input logic [COORD_W-1:0] z);
        send_request(FUNC_LOOKUP, ADDR_W'($urandom), {$urandom, $urandom}, x, y, z);
        lookup_count++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Wait for every due result, then let a write or late miss finish.
    // The first edge lets the checker's count catch up with the last request.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [WORD_W-1:0] leaf_pattern();
        case ($urandom_range(3, 0))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [CHILD_BITS-1:0] child_mask();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 5) return '0;
        if (roll < 15) return '1;
        return CHILD_BITS'($urandom);
    endfunction

    // Sequential word allocation; wraps at the top of memory on purpose.
    function automatic logic [ADDR_W-1:0] take_words(input int count);
        logic [ADDR_W-1:0] first;
        first    = alloc_at;
        alloc_at = ADDR_W'(alloc_at + count);
        return first;
    endfunction

    // Mask word (junk above the child bits) plus one pointer per set bit,
    // each pointing into the level below with junk above the address bits.
    task automatic write_node(input logic [ADDR_W-1:0] addr, input logic [CHILD_BITS-1:0] mask);
        logic [WORD_W-1:0] word;
        word                   = {$urandom, $urandom};
        word[CHILD_BITS-1:0]   = mask;
        write_word(addr, word);
        for (int k = 0; k < $countones(mask); k++) begin
            word               = {$urandom, $urandom};
            word[ADDR_W-1:0]   = lower_level[$urandom_range(lower_level.size() - 1, 0)];
            write_word(ADDR_W'(addr + 1 + k), word);
        end
        inner_words.push_back(addr);
    endtask

    // Build bottom-up so child addresses are known; the root slot is reserved
    // first so that the root lands exactly at base. Children are shared
    // between parents, which gives a DAG rather than a tree.
    task automatic build_dag(input int levels, input logic [ADDR_W-1:0] base);
        logic [CHILD_BITS-1:0] root_mask;
        logic [CHILD_BITS-1:0] mask;
        logic [ADDR_W-1:0]     addr;
        root_mask = CHILD_BITS'($urandom_range(2**CHILD_BITS - 1, 1));
        dag_root  = base;
        alloc_at  = ADDR_W'(base + 1 + $countones(root_mask));
        leaf_words.delete();
        inner_words.delete();
        lower_level.delete();
        repeat ($urandom_range(4, 1)) begin
            addr = take_words(1);
            write_word(addr, leaf_pattern());
            leaf_words.push_back(addr);
            lower_level.push_back(addr);
        end
        for (int lvl = 0; lvl < levels - 3; lvl++) begin
            upper_level.delete();
            repeat ($urandom_range(3, 1)) begin
                mask = child_mask();
                addr = take_words(1 + $countones(mask));
                write_node(addr, mask);
                upper_level.push_back(addr);
            end
            lower_level = upper_level;
        end
        write_node(dag_root, root_mask);
    endtask

    // Mostly trace a live path through the image so lookups reach the
    // leaves; now and then probe an empty octant or use raw coordinates.
    // Bits above the tree depth stay random throughout.
    task automatic lookup_request(input int levels);
        logic [COORD_W-1:0]    x;
        logic [COORD_W-1:0]    y;
        logic [COORD_W-1:0]    z;
        logic [ADDR_W-1:0]     node;
        logic [CHILD_BITS-1:0] m;
        logic [2:0]            d;
        x = COORD_W'($urandom);
        y = COORD_W'($urandom);
        z = COORD_W'($urandom);
        if ($urandom_range(99, 0) < FOLLOW_PERCENT) begin
            node = dag_root;
            for (int b = levels - 1; b >= 2; b--) begin
                m = dag_image[node][CHILD_BITS-1:0];
                d = 3'($urandom);
                if (m != '0 && $urandom_range(9, 0) != 0) begin
                    while (!m[d]) d = d + 3'd1;
                end
                x[b] = d[0];
                y[b] = d[1];
                z[b] = d[2];
                if (!m[d]) break;
                node = dag_image[ADDR_W'(node + 1 + $countones(m & ((8'd1 << d) - 8'd1)))]
                                [ADDR_W-1:0];
            end
        end
        query(x, y, z);
    endtask

    // Rewrites that keep the DAG walkable: new leaf bits, or a mask with
    // children removed (remaining children index into already written slots).
    task automatic noise_write();
        logic [ADDR_W-1:0] target;
        logic [WORD_W-1:0] word;
        if ($urandom_range(1, 0) == 1) begin
            target               = inner_words[$urandom_range(inner_words.size() - 1, 0)];
            word                 = {$urandom, $urandom};
            word[CHILD_BITS-1:0] = dag_image[target][CHILD_BITS-1:0] & CHILD_BITS'($urandom);
        end else begin
            target = leaf_words[$urandom_range(leaf_words.size() - 1, 0)];
            word   = leaf_pattern();
        end
        write_word(target, word);
        noise_count++;
    endtask

    task automatic run_phase(input int phase);
        int                setting;
        int                levels;
        logic [ADDR_W-1:0] base;
        setting = (phase < 7) ? level_plan[phase] : $urandom_range(LEVEL_CODE_MAX, 0);
        levels  = (setting < MIN_LEVELS) ? MIN_LEVELS :
                  (setting > MAX_LEVELS) ? MAX_LEVELS : setting;
        // root at the top of memory first, so node+1 wraps to word 0
        if (phase == 0) base = '1;
        else if (phase == 1) base = '0;
        else if ($urandom_range(3, 0) == 0) base = ADDR_W'($urandom_range(MEM_WORDS - 1,
                                                                          MEM_WORDS - 128));
        else base = ADDR_W'($urandom);
        if (setting < setting_lo) setting_lo = setting;
        if (setting > setting_hi) setting_hi = setting;

        settle();
        no_gaps <= (phase == 2);
        build_dag(levels, base);
        settle();

        // registers only while idle; an unmapped index must change nothing
        if ($urandom_range(1, 0) == 1) begin
            write_register(CFG_IDX_W'($urandom_range(LAST_INDEX, FIRST_SPARE_INDEX)),
                           CFG_DATA_W'($urandom));
        end
        write_register(CFG_ROOT_ADDRESS, base);
        write_register(CFG_LEVEL_COUNT, {8'($urandom), LEVEL_W'(setting)});
        cfg_valid <= 1'b0;

        repeat (LOOKUPS_PER_PHASE) begin
            if ($urandom_range(99, 0) < NOISE_PERCENT) noise_write();
            else lookup_request(levels);
        end
        phase_count++;
    endtask

    initial begin
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_func         <= FUNC_WRITE;
        s_word_address <= '0;
        s_word_data    <= '0;
        s_coord_x      <= '0;
        s_coord_y      <= '0;
        s_coord_z      <= '0;
        cfg_valid      <= 1'b0;
        cfg_index      <= CFG_ROOT_ADDRESS;
        cfg_data       <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed tree under the reset registers (root 0, three levels):
        // root mask has junk above the child bits and children at octants
        // 0, 2, 5 and 7; octants 2 and 7 share a leaf; octant 0's pointer
        // has all upper bits set and lands on the last word of memory.
        write_word(12'd0,    64'hFFFF_FFFF_FFFF_FFA5);
        write_word(12'd1,    64'hFFFF_FFFF_FFFF_FFFF);
        write_word(12'd2,    64'h0000_0000_0000_0010);
        write_word(12'd3,    64'h8000_0000_0000_0011);
        write_word(12'd4,    64'h0000_0000_0000_0010);
        write_word(12'hFFF,  64'hFFFF_FFFF_FFFF_FFFF);
        write_word(12'd16,   64'h8000_0000_0000_0001);
        write_word(12'd17,   64'h0000_0000_0000_0000);
        query(10'd0,    10'd0,    10'd0);       // leaf bit 0
        query(10'd3,    10'd3,    10'd3);       // leaf bit 63
        query(10'd4,    10'd0,    10'd0);       // absent child
        query(10'd4,    10'd4,    10'd0);       // absent child
        query(10'd0,    10'd4,    10'd0);       // shared leaf, low end
        query(10'd3,    10'd7,    10'd3);       // shared leaf, top bit
        query(10'd1,    10'd4,    10'd0);       // clear bit in a set leaf
        query(10'd4,    10'd0,    10'd4);       // empty leaf word
        query(10'd7,    10'd7,    10'd7);       // last octant, top bit
        query(10'h3FF,  10'h3FF,  10'h3FF);     // high coordinate bits ignored
        query(10'h3F8,  10'd0,    10'h3FF);     // high bits ignored, absent child
        query(10'd2,    10'd1,    10'd0);

        for (int phase = 0; item_count < ITEM_TARGET; phase++) begin
            run_phase(phase);
        end
        settle();

        $display("Run covered %0d memory writes (%0d rewrites) and %0d lookups, %0d occupied,",
                 write_count, noise_count, lookup_count, hits);
        $display("over %0d loaded DAGs with level_count written from %0d to %0d.",
                 phase_count, setting_lo, setting_hi);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/vdol_pkg.sv
rtl/core/vdol_ram.sv
rtl/core/vdol_ctrl.sv
rtl/core/vdol_dp.sv
rtl/core/voxel_dag_occupancy_lookup.sv
dv/voxel_dag_occupancy_checker.sv
dv/voxel_dag_occupancy_lookup_test.sv
